// ----- design/asw_pkg.sv -----
// Shared types, codes and helpers for the alive-supervision watchdog manager.
// Used by asw_entity_unit and alive_supervision_watchdog_manager; no dependencies.
package asw_pkg;

  // Default configuration of the block.
  localparam int NUM_ENTITIES_DEF = 8;
  localparam int COUNT_WIDTH_DEF  = 16;

  // Field widths of one input transfer.
  localparam int FUNC_W   = 3;
  localparam int ENT_W    = 3;
  localparam int REF_W    = 16;
  localparam int EXP_W    = 16;
  localparam int MARGIN_W = 15;
  localparam int TOL_W    = 8;

  // Signed width of the per-entity alive-count bounds (worst case +163835).
  localparam int BND_W = 19;

  // Item function codes.
  localparam logic [FUNC_W-1:0] FN_TICK   = 3'd0;
  localparam logic [FUNC_W-1:0] FN_ALIVE  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_ACT    = 3'd2;
  localparam logic [FUNC_W-1:0] FN_DEACT  = 3'd3;
  localparam logic [FUNC_W-1:0] FN_LOAD   = 3'd4;

  // Supervision status codes, ordered by severity.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FAILED  = 2'd1;
  localparam logic [1:0] ST_EXPIRED = 2'd2;
  localparam logic [1:0] ST_STOPPED = 2'd3;

  // Saturation value of the 8-bit failed-cycle and expired-tick counters.
  localparam logic [7:0] SAT_MAX = 8'hFF;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_ITEM,
    S_LOAD2,
    S_SWEEP,
    S_GLOBAL,
    S_DONE
  } state_t;

  // Operations the entity unit performs on the addressed entry.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_ALIVE,
    OP_ACT,
    OP_DEACT,
    OP_LOAD_A,
    OP_LOAD_B,
    OP_CHECK
  } ent_op_t;

  // Command from the sequencer to the entity unit.
  typedef struct packed {
    ent_op_t               op;
    logic [REF_W-1:0]      ref_cycle;
    logic [EXP_W-1:0]      expected_alive;
    logic [MARGIN_W-1:0]   min_margin;
    logic [MARGIN_W-1:0]   max_margin;
    logic [TOL_W-1:0]      fail_tolerance;
    logic                  enable_at_load;
  } ent_cmd_t;

  // Width of an entity table index.
  function automatic int idx_w(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage

// ----- design/alive_supervision_watchdog_manager.sv -----
// Top level of the alive-supervision watchdog manager: sequencer, global status, ports.
// Depends on asw_pkg and asw_entity_unit.
//
// Usage: each transfer on the in_ channel carries one command (tick, alive indication,
// activate, deactivate or load of one entity's settings). Every command yields exactly
// one transfer on the out_ channel with the global status after the command and the
// alive flag that permits a watchdog kick.
// The block works on one command at a time; in_tready is high only while it is idle.
// Alive, activate, deactivate and ignored commands pass through the item state, a load
// through two table write steps (item and second load state), and a tick through the
// sweep, where the shared check unit visits one entity per cycle, and the global update.
// All then load the output register from the done state and return to idle, where
// in_tready rises in the same cycle as out_tvalid.
// The result sits in an output register; the next command is taken while it waits,
// but a finished command holds the sequencer until the previous result has left.
// The cfg_ port writes the expired-tick tolerance; write it only while idle.
// Reset (rst_n low, synchronous) disables all entities, clears the counters, sets the
// global status to ok and the tolerance to 3; entity settings must be loaded again.
module alive_supervision_watchdog_manager #(
  parameter int NUM_ENTITIES = asw_pkg::NUM_ENTITIES_DEF,
  parameter int COUNT_WIDTH  = asw_pkg::COUNT_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // func, entity, ref_cycle, expected_alive, min_margin, max_margin,
  // fail_tolerance, enable_at_load (from bit 0 up), zero filled to 80 bits
  input  logic [79:0] in_tdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // global_status, alive (from bit 0 up), zero filled to 8 bits
  output logic [7:0]  out_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata
);

  localparam int EW = asw_pkg::idx_w(NUM_ENTITIES);

  asw_pkg::state_t state_r, state_nxt;

  logic [asw_pkg::FUNC_W-1:0] func_r;
  logic                       ent_ok_r;
  logic [EW-1:0]              addr_r;
  asw_pkg::ent_cmd_t          cmd_r;
  asw_pkg::ent_cmd_t          cmd;
  logic [1:0]                 worst_r;
  logic [1:0]                 sev;
  logic [1:0]                 glob_r;
  logic [7:0]                 exp_ticks_r;
  logic [7:0]                 tol_cfg_r;
  logic                       out_tvalid_r;
  logic [1:0]                 out_status_r;
  logic                       in_xfer;
  logic                       out_load;
  logic                       sweep_last;
  logic [asw_pkg::FUNC_W-1:0] in_func;
  logic [asw_pkg::ENT_W-1:0]  in_entity;
  logic [1:0]                 glob_a;
  logic [7:0]                 exp_ticks_a;

  assign in_func    = in_tdata[2:0];
  assign in_entity  = in_tdata[5:3];
  assign in_xfer    = in_tvalid && in_tready;
  assign sweep_last = (addr_r == EW'(NUM_ENTITIES - 1));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      asw_pkg::S_IDLE: begin
        if (in_xfer) begin
          state_nxt = (in_func == asw_pkg::FN_TICK) ? asw_pkg::S_SWEEP : asw_pkg::S_ITEM;
        end
      end
      asw_pkg::S_ITEM: begin
        if (ent_ok_r && (func_r == asw_pkg::FN_LOAD)) begin
          state_nxt = asw_pkg::S_LOAD2;
        end else begin
          state_nxt = asw_pkg::S_DONE;
        end
      end
      asw_pkg::S_LOAD2:  state_nxt = asw_pkg::S_DONE;
      asw_pkg::S_SWEEP: begin
        if (sweep_last) begin
          state_nxt = asw_pkg::S_GLOBAL;
        end
      end
      asw_pkg::S_GLOBAL: state_nxt = asw_pkg::S_DONE;
      asw_pkg::S_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          state_nxt = asw_pkg::S_IDLE;
        end
      end
      default: state_nxt = asw_pkg::S_IDLE;
    endcase
  end

  // Sequencer outputs: handshake and entity unit command.
  always_comb begin
    cmd       = cmd_r;
    cmd.op    = asw_pkg::OP_NONE;
    in_tready = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      asw_pkg::S_IDLE: in_tready = 1'b1;
      asw_pkg::S_ITEM: begin
        if (ent_ok_r) begin
          priority case (func_r)
            asw_pkg::FN_ALIVE: cmd.op = asw_pkg::OP_ALIVE;
            asw_pkg::FN_ACT:   cmd.op = asw_pkg::OP_ACT;
            asw_pkg::FN_DEACT: cmd.op = asw_pkg::OP_DEACT;
            asw_pkg::FN_LOAD:  cmd.op = asw_pkg::OP_LOAD_A;
            default:           cmd.op = asw_pkg::OP_NONE;
          endcase
        end
      end
      asw_pkg::S_LOAD2: cmd.op = asw_pkg::OP_LOAD_B;
      asw_pkg::S_SWEEP: cmd.op = asw_pkg::OP_CHECK;
      asw_pkg::S_DONE:  out_load = !out_tvalid_r || out_tready;
      default: begin
      end
    endcase
  end

  // Global status update at the end of a tick; expired sticks, enough expired ticks stop.
  always_comb begin
    glob_a      = (glob_r != asw_pkg::ST_EXPIRED) ? worst_r : glob_r;
    exp_ticks_a = exp_ticks_r;
    if ((glob_a == asw_pkg::ST_EXPIRED) && (exp_ticks_r != asw_pkg::SAT_MAX)) begin
      exp_ticks_a = exp_ticks_r + 8'd1;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= asw_pkg::S_IDLE;
      glob_r       <= asw_pkg::ST_OK;
      exp_ticks_r  <= '0;
      tol_cfg_r    <= 8'd3;
      out_tvalid_r <= 1'b0;
      worst_r      <= asw_pkg::ST_OK;
      addr_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        tol_cfg_r <= cfg_wdata;
      end
      if (in_xfer) begin
        worst_r <= asw_pkg::ST_OK;
        addr_r  <= (in_func == asw_pkg::FN_TICK) ? '0 : EW'(in_entity);
      end else if (state_r == asw_pkg::S_SWEEP) begin
        if (sev > worst_r) begin
          worst_r <= sev;
        end
        if (!sweep_last) begin
          addr_r <= addr_r + 1'b1;
        end
      end
      if (state_r == asw_pkg::S_GLOBAL) begin
        exp_ticks_r <= exp_ticks_a;
        glob_r      <= (exp_ticks_a >= tol_cfg_r) ? asw_pkg::ST_STOPPED : glob_a;
      end
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // Command payload and result data.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      func_r               <= in_func;
      ent_ok_r             <= (32'(in_entity) < NUM_ENTITIES);
      cmd_r.op             <= asw_pkg::OP_NONE;
      cmd_r.ref_cycle      <= in_tdata[21:6];
      cmd_r.expected_alive <= in_tdata[37:22];
      cmd_r.min_margin     <= in_tdata[52:38];
      cmd_r.max_margin     <= in_tdata[67:53];
      cmd_r.fail_tolerance <= in_tdata[75:68];
      cmd_r.enable_at_load <= in_tdata[76];
    end
    if (out_load) begin
      out_status_r <= glob_r;
    end
  end

  asw_entity_unit #(
    .NUM_ENTITIES (NUM_ENTITIES),
    .COUNT_WIDTH  (COUNT_WIDTH)
  ) u_entity (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .addr  (addr_r),
    .sev   (sev)
  );

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {5'd0, (out_status_r != asw_pkg::ST_STOPPED), out_status_r};

endmodule

// ----- design/asw_entity_unit.sv -----
// Per-entity supervision table and the shared check unit that serves one entry per cycle.
// Depends on asw_pkg.
module asw_entity_unit #(
  parameter int NUM_ENTITIES = asw_pkg::NUM_ENTITIES_DEF,
  parameter int COUNT_WIDTH  = asw_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  asw_pkg::ent_cmd_t                         cmd,
  input  logic [asw_pkg::idx_w(NUM_ENTITIES)-1:0]   addr,
  output logic [1:0]                                sev
);

  localparam int MATCH_W = (COUNT_WIDTH > asw_pkg::REF_W) ? COUNT_WIDTH : asw_pkg::REF_W;
  localparam int CMP_W   = ((COUNT_WIDTH > asw_pkg::BND_W) ? COUNT_WIDTH : asw_pkg::BND_W) + 1;

  // Counters and flags, cleared by reset.
  logic                   enabled_r [NUM_ENTITIES];
  logic [COUNT_WIDTH-1:0] cyc_r     [NUM_ENTITIES];
  logic [COUNT_WIDTH-1:0] alv_r     [NUM_ENTITIES];
  logic [7:0]             fail_r    [NUM_ENTITIES];

  // Settings, valid once loaded.
  logic [asw_pkg::REF_W-1:0] ref_r [NUM_ENTITIES];
  logic [asw_pkg::TOL_W-1:0] tol_r [NUM_ENTITIES];
  logic signed [asw_pkg::BND_W-1:0] lo_r [NUM_ENTITIES];
  logic signed [asw_pkg::BND_W-1:0] hi_r [NUM_ENTITIES];

  // Balance offset minus reference cycle, kept between the two load steps.
  logic signed [asw_pkg::BND_W-1:0] adj_r;
  logic signed [asw_pkg::BND_W-1:0] adj_nxt;

  logic                   en;
  logic [COUNT_WIDTH-1:0] cyc_new;
  logic                   match;
  logic signed [CMP_W-1:0] alv_ext;
  logic signed [CMP_W-1:0] lo_ext;
  logic signed [CMP_W-1:0] hi_ext;
  logic                   in_range;
  logic                   failed;
  logic                   expire;

  // At a match the balance is alive + adj, so the margins become bounds on alive.
  always_comb begin
    en       = enabled_r[addr];
    cyc_new  = COUNT_WIDTH'(cyc_r[addr] + 1'b1);
    match    = en && (MATCH_W'(cyc_new) == MATCH_W'(ref_r[addr]));
    alv_ext  = $signed(CMP_W'(alv_r[addr]));
    lo_ext   = CMP_W'(lo_r[addr]);
    hi_ext   = CMP_W'(hi_r[addr]);
    in_range = (alv_ext >= lo_ext) && (alv_ext <= hi_ext);
    failed   = match && !in_range;
    expire   = failed && (fail_r[addr] > tol_r[addr]);
    if (!failed) begin
      sev = asw_pkg::ST_OK;
    end else if (expire) begin
      sev = asw_pkg::ST_EXPIRED;
    end else begin
      sev = asw_pkg::ST_FAILED;
    end
  end

  // First load step: offset is 1 - expected when expected exceeds the cycle, else cycle - 1.
  always_comb begin
    if (cmd.expected_alive > cmd.ref_cycle) begin
      adj_nxt = asw_pkg::BND_W'(1) - $signed(asw_pkg::BND_W'(cmd.expected_alive))
              - $signed(asw_pkg::BND_W'(cmd.ref_cycle));
    end else begin
      adj_nxt = -asw_pkg::BND_W'(1);
    end
  end

  // Counters and enable bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_ENTITIES; i++) begin
        enabled_r[i] <= 1'b0;
        cyc_r[i]     <= '0;
        alv_r[i]     <= '0;
        fail_r[i]    <= '0;
      end
    end else begin
      unique case (cmd.op)
        asw_pkg::OP_ALIVE: begin
          if (en) begin
            alv_r[addr] <= COUNT_WIDTH'(alv_r[addr] + 1'b1);
          end
        end
        asw_pkg::OP_ACT:    enabled_r[addr] <= 1'b1;
        asw_pkg::OP_DEACT:  enabled_r[addr] <= 1'b0;
        asw_pkg::OP_LOAD_A: enabled_r[addr] <= cmd.enable_at_load;
        asw_pkg::OP_CHECK: begin
          if (match) begin
            cyc_r[addr] <= '0;
            alv_r[addr] <= '0;
            if (failed && !expire && (fail_r[addr] != asw_pkg::SAT_MAX)) begin
              fail_r[addr] <= fail_r[addr] + 8'd1;
            end
          end else if (en) begin
            cyc_r[addr] <= cyc_new;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Settings, written in two load steps.
  always_ff @(posedge clk) begin
    if (cmd.op == asw_pkg::OP_LOAD_A) begin
      ref_r[addr] <= cmd.ref_cycle;
      tol_r[addr] <= cmd.fail_tolerance;
      adj_r       <= adj_nxt;
    end
    if (cmd.op == asw_pkg::OP_LOAD_B) begin
      hi_r[addr] <= $signed(asw_pkg::BND_W'(cmd.max_margin)) - adj_r;
      lo_r[addr] <= -$signed(asw_pkg::BND_W'(cmd.min_margin)) - adj_r;
    end
  end

endmodule

// ----- sim/alive_supervision_watchdog_manager_tb.sv -----
// Self-checking testbench for alive_supervision_watchdog_manager: drives tick, alive,
// activate, deactivate and load transfers and checks each status result against a model.
// Depends on asw_pkg and the RTL of the block; needs no files or arguments.
module alive_supervision_watchdog_manager_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NE = asw_pkg::NUM_ENTITIES_DEF;
  localparam int QUIET_LIMIT = 4000;
  localparam int ITEMS_PER_PHASE = 345;
  localparam int NUM_PHASES = 5;

  // Function codes the block ignores.
  localparam logic [asw_pkg::FUNC_W-1:0] FN_UNUSED_LO = 3'd5;
  localparam logic [asw_pkg::FUNC_W-1:0] FN_UNUSED_HI = 3'd7;

  // One command on the input stream.
  typedef struct {
    logic [asw_pkg::FUNC_W-1:0]   func;
    logic [asw_pkg::ENT_W-1:0]    entity;
    logic [asw_pkg::REF_W-1:0]    ref_cycle;
    logic [asw_pkg::EXP_W-1:0]    expected;
    logic [asw_pkg::MARGIN_W-1:0] min_margin;
    logic [asw_pkg::MARGIN_W-1:0] max_margin;
    logic [asw_pkg::TOL_W-1:0]    fail_tol;
    logic                         enable;
  } cmd_t;

  // Fields of one result transfer.
  typedef struct {
    logic [1:0] status;
    logic       alive;
  } status_t;

  // Tracks the supervision state of all entities and checks the status stream.
  class status_tracker;
    bit                         entity_on[NE];
    bit [asw_pkg::REF_W-1:0]    cycles[NE];
    bit [asw_pkg::REF_W-1:0]    alives[NE];
    bit [1:0]                   ent_st[NE];
    bit [7:0]                   fails[NE];
    bit [asw_pkg::REF_W-1:0]    ref_cyc[NE];
    bit [asw_pkg::EXP_W-1:0]    exp_alive[NE];
    bit [asw_pkg::MARGIN_W-1:0] min_m[NE];
    bit [asw_pkg::MARGIN_W-1:0] max_m[NE];
    bit [asw_pkg::TOL_W-1:0]    fail_tol[NE];
    bit [1:0]                   glob;
    bit [7:0]                   expired_cnt;
    bit [7:0]                   tick_tol;
    status_t                    pending[$];
    int unsigned                errors;

    function new();
      glob = asw_pkg::ST_OK;
      expired_cnt = 8'd0;
      tick_tol = 8'd3;
      errors = 0;
    endfunction

    function void set_tolerance(bit [7:0] v);
      tick_tol = v;
    endfunction

    // Applies one accepted command and queues the status it must produce.
    function void apply_item(cmd_t c);
      bit [1:0] worst;
      longint offset;
      longint balance;
      status_t s;
      case (c.func)
        asw_pkg::FN_TICK: begin
          worst = asw_pkg::ST_OK;
          for (int e = 0; e < NE; e++) begin
            if (!entity_on[e]) continue;
            cycles[e] = cycles[e] + 1'b1;
            if (cycles[e] != ref_cyc[e]) continue;
            // Balance of alive indications against the reference cycle.
            if (exp_alive[e] > ref_cyc[e]) offset = 1 - longint'(exp_alive[e]);
            else offset = longint'(ref_cyc[e]) - 1;
            balance = longint'(alives[e]) - longint'(cycles[e]) + offset;
            if (balance <= longint'(max_m[e]) && balance >= -longint'(min_m[e])) begin
              ent_st[e] = asw_pkg::ST_OK;
            end else begin
              ent_st[e] = asw_pkg::ST_FAILED;
              if (worst < asw_pkg::ST_FAILED) worst = asw_pkg::ST_FAILED;
              if (fails[e] > fail_tol[e]) begin
                ent_st[e] = asw_pkg::ST_EXPIRED;
                worst = asw_pkg::ST_EXPIRED;
              end else if (fails[e] != asw_pkg::SAT_MAX) begin
                fails[e]++;
              end
            end
            cycles[e] = '0;
            alives[e] = '0;
          end
          // Expired sticks; enough expired ticks force stopped.
          if (glob != asw_pkg::ST_EXPIRED) glob = worst;
          if (glob == asw_pkg::ST_EXPIRED && expired_cnt != asw_pkg::SAT_MAX) expired_cnt++;
          if (expired_cnt >= tick_tol) glob = asw_pkg::ST_STOPPED;
        end
        asw_pkg::FN_ALIVE: begin
          if (entity_on[c.entity]) alives[c.entity] = alives[c.entity] + 1'b1;
        end
        asw_pkg::FN_ACT:   entity_on[c.entity] = 1'b1;
        asw_pkg::FN_DEACT: entity_on[c.entity] = 1'b0;
        asw_pkg::FN_LOAD: begin
          ref_cyc[c.entity]   = c.ref_cycle;
          exp_alive[c.entity] = c.expected;
          min_m[c.entity]     = c.min_margin;
          max_m[c.entity]     = c.max_margin;
          fail_tol[c.entity]  = c.fail_tol;
          entity_on[c.entity] = c.enable;
        end
        default: ;
      endcase
      s.status = glob;
      s.alive = (glob != asw_pkg::ST_STOPPED);
      pending.push_back(s);
    endfunction

    // Compares one result transfer with the oldest queued status.
    function void check_status(logic [1:0] st, logic al);
      status_t s;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: status %0d alive %0d", st, al);
        return;
      end
      s = pending.pop_front();
      if (st !== s.status || al !== s.alive) begin
        errors++;
        if (errors <= 10)
          $display("status mismatch: expected status %0d alive %0d, got status %0d alive %0d",
                   s.status, s.alive, st, al);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic [79:0] in_tdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  out_tdata;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic        cfg_we = 1'b0;
  logic [7:0]  cfg_wdata = '0;

  status_tracker tracker;
  bit            settings_loaded[NE];
  int unsigned   send_gap_pct = 0;
  int unsigned   stall_pct = 0;
  int unsigned   quiet_cycles = 0;

  alive_supervision_watchdog_manager u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #6 clk = ~clk;

  function automatic logic [79:0] pack_cmd(cmd_t c);
    return {3'b000, c.enable, c.fail_tol, c.max_margin, c.min_margin, c.expected,
            c.ref_cycle, c.entity, c.func};
  endfunction

  function automatic cmd_t unpack_cmd(logic [79:0] d);
    cmd_t c;
    c.func       = d[2:0];
    c.entity     = d[5:3];
    c.ref_cycle  = d[21:6];
    c.expected   = d[37:22];
    c.min_margin = d[52:38];
    c.max_margin = d[67:53];
    c.fail_tol   = d[75:68];
    c.enable     = d[76];
    return c;
  endfunction

  // Command with the given code and entity; unused fields carry random bits.
  function automatic cmd_t mk_cmd(logic [asw_pkg::FUNC_W-1:0] func,
                                  logic [asw_pkg::ENT_W-1:0] ent);
    cmd_t c;
    c.func       = func;
    c.entity     = ent;
    c.ref_cycle  = asw_pkg::REF_W'($urandom_range(65535, 1));
    c.expected   = asw_pkg::EXP_W'($urandom);
    c.min_margin = asw_pkg::MARGIN_W'($urandom);
    c.max_margin = asw_pkg::MARGIN_W'($urandom);
    c.fail_tol   = asw_pkg::TOL_W'($urandom_range(254, 0));
    c.enable     = 1'($urandom);
    return c;
  endfunction

  function automatic cmd_t mk_load(logic [asw_pkg::ENT_W-1:0] ent, int rc, int ex, int mn,
                                   int mx, int tl, bit en);
    cmd_t c;
    c = mk_cmd(asw_pkg::FN_LOAD, ent);
    c.ref_cycle  = asw_pkg::REF_W'(rc);
    c.expected   = asw_pkg::EXP_W'(ex);
    c.min_margin = asw_pkg::MARGIN_W'(mn);
    c.max_margin = asw_pkg::MARGIN_W'(mx);
    c.fail_tol   = asw_pkg::TOL_W'(tl);
    c.enable     = en;
    return c;
  endfunction

  // Load with mostly short reference cycles so that supervision cycles complete often.
  function automatic cmd_t rand_load(logic [asw_pkg::ENT_W-1:0] ent);
    cmd_t c;
    int unsigned r;
    c = mk_cmd(asw_pkg::FN_LOAD, ent);
    if ($urandom_range(99) < 90) c.ref_cycle = asw_pkg::REF_W'($urandom_range(6, 1));
    if ($urandom_range(99) < 80) c.expected = asw_pkg::EXP_W'($urandom_range(8, 0));
    if ($urandom_range(99) < 75) c.min_margin = asw_pkg::MARGIN_W'($urandom_range(3, 0));
    if ($urandom_range(99) < 75) c.max_margin = asw_pkg::MARGIN_W'($urandom_range(3, 0));
    r = $urandom_range(99);
    if (r < 80) c.fail_tol = asw_pkg::TOL_W'($urandom_range(254, 150));
    else if (r < 90) c.fail_tol = asw_pkg::TOL_W'($urandom_range(4, 0));
    c.enable = ($urandom_range(99) < 80);
    return c;
  endfunction

  function automatic cmd_t rand_cmd();
    cmd_t c;
    int unsigned r;
    logic [asw_pkg::ENT_W-1:0] ent;
    r = $urandom_range(99);
    ent = asw_pkg::ENT_W'($urandom);
    if (r < 45) c = mk_cmd(asw_pkg::FN_TICK, ent);
    else if (r < 80) c = mk_cmd(asw_pkg::FN_ALIVE, ent);
    else if (r < 86) c = rand_load(ent);
    else if (r < 92) begin
      // Only entities with settings may be enabled; otherwise load them first.
      if (settings_loaded[ent]) c = mk_cmd(asw_pkg::FN_ACT, ent);
      else c = rand_load(ent);
    end else if (r < 97) c = mk_cmd(asw_pkg::FN_DEACT, ent);
    else c = mk_cmd(asw_pkg::FUNC_W'($urandom_range(FN_UNUSED_HI, FN_UNUSED_LO)), ent);
    return c;
  endfunction

  // Presents one command, with random gaps, until the block takes the transfer.
  task automatic send_item(cmd_t c);
    @(negedge clk);
    while ($urandom_range(99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pack_cmd(c);
    if (c.func == asw_pkg::FN_LOAD) settings_loaded[c.entity] = 1'b1;
    do @(posedge clk); while (!in_tready);
  endtask

  // Holds the input idle until every queued status has come back.
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk);
  endtask

  task automatic write_tolerance(logic [7:0] v);
    drain();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    tracker.set_tolerance(v);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Receiver side: random backpressure per phase.
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Transfer monitor and stall watchdog.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) tracker.check_status(out_tdata[1:0], out_tdata[2]);
      if (in_tvalid && in_tready) tracker.apply_item(unpack_cmd(in_tdata));
      if ((out_tvalid && out_tready) || (in_tvalid && in_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    cmd_t c;
    int unsigned counted;
    logic [7:0] tol;
    tracker = new();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset tolerance of three expired ticks.
    send_item(mk_cmd(asw_pkg::FN_TICK, 3'd0));
    send_item(mk_cmd(FN_UNUSED_HI, 3'd2));
    // Activate and deactivate an entity that has no settings, with no tick between.
    send_item(mk_cmd(asw_pkg::FN_ACT, 3'd6));
    send_item(mk_cmd(asw_pkg::FN_DEACT, 3'd6));
    // Tight entity: one tick per cycle, no alive expected, zero margins and tolerance.
    send_item(mk_load(3'd0, 1, 0, 0, 0, 0, 1'b1));
    send_item(mk_cmd(asw_pkg::FN_TICK, 3'd5));
    send_item(mk_cmd(asw_pkg::FN_ALIVE, 3'd0));
    send_item(mk_cmd(asw_pkg::FN_TICK, 3'd1));
    // Second failure exceeds the tolerance: expired, then stopped after three ticks.
    send_item(mk_cmd(asw_pkg::FN_TICK, 3'd7));
    send_item(mk_cmd(asw_pkg::FN_TICK, 3'd0));
    send_item(mk_cmd(asw_pkg::FN_TICK, 3'd4));
    // Largest settings, and expected count above the reference cycle with enable off.
    send_item(mk_load(3'd7, 65535, 65535, 32767, 32767, 254, 1'b1));
    send_item(mk_load(3'd0, 2, 5, 0, 0, 254, 1'b0));
    send_item(mk_cmd(asw_pkg::FN_ALIVE, 3'd7));
    send_item(mk_cmd(asw_pkg::FN_ALIVE, 3'd3));
    send_item(mk_cmd(asw_pkg::FN_TICK, 3'd2));
    send_item(mk_cmd(asw_pkg::FN_ACT, 3'd0));
    send_item(mk_cmd(asw_pkg::FN_ALIVE, 3'd0));
    send_item(mk_cmd(asw_pkg::FN_TICK, 3'd0));
    send_item(mk_cmd(asw_pkg::FN_TICK, 3'd0));
    send_item(mk_cmd(asw_pkg::FN_DEACT, 3'd7));
    send_item(mk_cmd(FN_UNUSED_LO, 3'd1));

    // Random phases, each with its own tolerance and idling pattern.
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin tol = 8'd255;                      send_gap_pct = 0;  stall_pct = 0;  end
        1: begin tol = 8'd0;                        send_gap_pct = 70; stall_pct = 0;  end
        2: begin tol = 8'd255;                      send_gap_pct = 0;  stall_pct = 70; end
        3: begin tol = 8'($urandom_range(254, 2));  send_gap_pct = 14; stall_pct = 14; end
        default: begin tol = 8'd1;                  send_gap_pct = 0;  stall_pct = 0;  end
      endcase
      write_tolerance(tol);
      counted = 0;
      while (counted < ITEMS_PER_PHASE) begin
        c = rand_cmd();
        send_item(c);
        if (c.func <= asw_pkg::FN_LOAD) counted++;
        if ($urandom_range(99) == 0) drain();
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
